@@ design/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg
// Shared widths, codes and control types of the segment / circle contact search.
// ----------------------------------------------------------------------------
package scs_pkg;

    // number of sample points along the segment
    localparam int STEPS     = 100;
    // coordinate format: signed, FRAC_BITS fraction bits (fraction does not change the math)
    localparam int FRAC_BITS = 8;
    localparam int COORD_W   = 24;
    localparam int RAD_W     = COORD_W - 1;
    localparam int TOL_W     = 8;
    // product of two coordinate magnitudes, and the sum of two such products
    localparam int SQ_W      = 2 * COORD_W;
    localparam int D2_W      = SQ_W + 1;
    // remainder of a division by STEPS
    localparam int STEP_W    = (STEPS > 2) ? $clog2(STEPS) : 1;
    // sample counter, reaches STEPS
    localparam int K_W       = $clog2(STEPS + 1);
    // setup cycles: span split and the three band squares
    localparam int SETUP_CYC = 4;
    localparam int DCNT_W    = $clog2(SETUP_CYC);

    // reciprocal of STEPS, exact for every magnitude below 2^COORD_W
    localparam int     RECIP_SH = COORD_W + STEP_W;
    localparam int     RECIP_W  = COORD_W + 1;
    localparam longint RECIP_M  = ((longint'(1) <<< RECIP_SH) + STEPS - 1) / STEPS;

    // stream payload widths
    localparam int IN_FLD_W  = RAD_W + 6 * COORD_W;
    localparam int IN_W      = ((IN_FLD_W + 7) / 8) * 8;
    localparam int OUT_W     = ((2 * COORD_W + 7) / 8) * 8;
    localparam int KIND_W    = 2;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(3);

    // match kinds
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSIDE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HIT    = 2'd2;

    // sequencer commands to one axis generator
    typedef struct packed {
        logic load;      // take the segment ends, start the split
        logic div_step;  // one step of the span / STEPS split
        logic adv_q;     // advance the quotient accumulator to the next sample
        logic adv_p;     // move the position register to the next sample
    } axis_ctl_t;

endpackage

@@ design/scs_axis.sv @@
// ----------------------------------------------------------------------------
// scs_axis
// Sample position generator for one axis: splits the span by STEPS with a
// reciprocal multiply, then steps second + trunc(span * k / STEPS).
// ----------------------------------------------------------------------------
module scs_axis
    import scs_pkg::*;
(
    input  logic                      aclk,
    input  axis_ctl_t                 ctl,
    input  logic signed [COORD_W-1:0] start_pt,
    input  logic signed [COORD_W-1:0] end_pt,
    output logic signed [COORD_W-1:0] pos
);

    localparam logic [STEP_W:0]    STEPS_C = (STEP_W + 1)'(STEPS);
    localparam int                 PROD_W  = COORD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP_M);

    logic signed [COORD_W:0] span;
    logic [COORD_W-1:0]      span_mag;

    logic [COORD_W-1:0] dvd_reg;
    logic [COORD_W-1:0] quo_reg;
    logic [STEP_W-1:0]  drem_reg;
    logic [COORD_W-1:0] q_reg;
    logic [STEP_W-1:0]  r_reg;
    logic [COORD_W-1:0] base_reg;
    logic               neg_reg;
    logic [COORD_W-1:0] pos_reg;

    logic [PROD_W-1:0]  recip_prod;
    logic [COORD_W-1:0] quo_calc;
    logic [COORD_W-1:0] drem_full;
    logic [STEP_W-1:0]  drem_next;
    logic [STEP_W:0]    sum;
    logic               sum_ge;
    logic [STEP_W-1:0]  r_next;
    logic [COORD_W-1:0] q_next;
    logic [COORD_W-1:0] pos_next;

    // span magnitude, at most 2^COORD_W - 1
    always_comb begin
        span     = {end_pt[COORD_W-1], end_pt} - {start_pt[COORD_W-1], start_pt};
        span_mag = span[COORD_W] ? COORD_W'(-span) : span[COORD_W-1:0];
    end

    // quotient by reciprocal multiply, remainder from the registered quotient
    always_comb begin
        recip_prod = PROD_W'(dvd_reg) * PROD_W'(RECIP_C);
        quo_calc   = COORD_W'(recip_prod[PROD_W-1:RECIP_SH]);
        drem_full  = dvd_reg - quo_reg * COORD_W'(STEPS);
        drem_next  = drem_full[STEP_W-1:0];
    end

    // floor(|span| * k / STEPS) kept as quotient and remainder
    always_comb begin
        sum      = {1'b0, r_reg} + {1'b0, drem_reg};
        sum_ge   = (sum >= STEPS_C);
        r_next   = sum_ge ? STEP_W'(sum - STEPS_C) : sum[STEP_W-1:0];
        q_next   = q_reg + quo_reg + COORD_W'(sum_ge);
        pos_next = neg_reg ? (base_reg - q_reg) : (base_reg + q_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            dvd_reg  <= span_mag;
            quo_reg  <= '0;
            drem_reg <= '0;
            q_reg    <= '0;
            r_reg    <= '0;
            base_reg <= start_pt;
            neg_reg  <= span[COORD_W];
            pos_reg  <= start_pt;
        end else begin
            if (ctl.div_step) begin
                quo_reg  <= quo_calc;
                drem_reg <= drem_next;
            end
            if (ctl.adv_q) begin
                q_reg <= q_next;
                r_reg <= r_next;
            end
            if (ctl.adv_p) begin
                pos_reg <= pos_next;
            end
        end
    end

    assign pos = pos_reg;

endmodule

@@ design/scs_square.sv @@
// ----------------------------------------------------------------------------
// scs_square
// Shared squaring unit: one unsigned square a cycle, product registered.
// ----------------------------------------------------------------------------
module scs_square
    import scs_pkg::*;
(
    input  logic               aclk,
    input  logic [COORD_W-1:0] operand,
    output logic [SQ_W-1:0]    product
);

    logic [SQ_W-1:0] prod_reg;

    // square and register
    always_ff @(posedge aclk) begin
        prod_reg <= SQ_W'(operand) * SQ_W'(operand);
    end

    assign product = prod_reg;

endmodule

@@ design/segment_circle_contact_search.sv @@
// ----------------------------------------------------------------------------
// segment_circle_contact_search
// Walks STEPS sample points from the second segment end toward the first and
// reports the first point on the circle within tolerance, else the last inside.
// ----------------------------------------------------------------------------
// sequence: setup in S_DIV, then S_WA and S_WB alternate over the samples, then S_OUT;
//   at most STEPS samples are tested, and a tolerance hit ends the walk early
// input: one beat at a time; the next input beat is taken once the result is in the
//   output register; the single shared squarer takes the x and y offsets of each sample in turn
// reset: aresetn low (synchronous) empties the block and sets hit_tolerance to 3
module segment_circle_contact_search
    import scs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration: hit_tolerance
    input  logic               cfg_we,
    input  logic [TOL_W-1:0]   cfg_wdata,
    // input beat
    input  logic               s_tvalid,
    output logic               s_tready,
    // fields from bit 0: circle_radius, center_x, center_y, first_x, first_y,
    // second_x, second_y, zero fill
    input  logic [IN_W-1:0]    s_tdata,
    // result beat
    output logic               m_tvalid,
    input  logic               m_tready,
    // fields from bit 0: contact_x, contact_y
    output logic [OUT_W-1:0]   m_tdata,
    // fields from bit 0: match_kind
    output logic [KIND_W-1:0]  m_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_WA,
        S_WB,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [TOL_W-1:0]    tol_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic [K_W-1:0]      k_reg;
    logic                have_reg;
    logic                last_reg;

    logic [RAD_W-1:0]    r_reg;
    logic [COORD_W-1:0]  lo_reg;
    logic [COORD_W-1:0]  hi_reg;
    logic [SQ_W-1:0]     r2_reg;
    logic [SQ_W-1:0]     lo2_reg;
    logic [SQ_W-1:0]     hi2_reg;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic [SQ_W-1:0]     sqx_reg;
    logic signed [COORD_W-1:0] hold_x_reg;
    logic signed [COORD_W-1:0] hold_y_reg;
    logic signed [COORD_W-1:0] res_x_reg;
    logic signed [COORD_W-1:0] res_y_reg;
    logic [KIND_W-1:0]   kind_reg;

    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic [KIND_W-1:0]   m_tuser_reg;

    // input fields
    logic [RAD_W-1:0]          in_r;
    logic signed [COORD_W-1:0] in_cx, in_cy, in_fx, in_fy, in_sx, in_sy;
    logic [RAD_W:0]            in_hi;
    logic [COORD_W-1:0]        in_lo;

    axis_ctl_t                 ctl;
    logic signed [COORD_W-1:0] px, py;
    logic signed [COORD_W:0]   diff_x, diff_y;
    logic [COORD_W-1:0]        mag_x, mag_y;
    logic [COORD_W-1:0]        mul_op;
    logic [SQ_W-1:0]           prod;
    logic [D2_W-1:0]           d2;
    logic                      hit, in_circle;
    logic                      in_acc;

    assign in_r  = s_tdata[RAD_W-1:0];
    assign in_cx = s_tdata[RAD_W +     COORD_W - 1 -: COORD_W];
    assign in_cy = s_tdata[RAD_W + 2 * COORD_W - 1 -: COORD_W];
    assign in_fx = s_tdata[RAD_W + 3 * COORD_W - 1 -: COORD_W];
    assign in_fy = s_tdata[RAD_W + 4 * COORD_W - 1 -: COORD_W];
    assign in_sx = s_tdata[RAD_W + 5 * COORD_W - 1 -: COORD_W];
    assign in_sy = s_tdata[RAD_W + 6 * COORD_W - 1 -: COORD_W];

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // tolerance band, lower edge clamped at zero
    always_comb begin
        in_hi = {1'b0, in_r} + (RAD_W + 1)'(tol_reg);
        in_lo = (in_r > RAD_W'(tol_reg)) ? COORD_W'(in_r - RAD_W'(tol_reg)) : '0;
    end

    // axis generator commands
    always_comb begin
        ctl.load     = in_acc;
        ctl.div_step = (state_reg == S_DIV);
        ctl.adv_q    = (state_reg == S_WA);
        ctl.adv_p    = (state_reg == S_WB);
    end

    scs_axis u_axis_x (
        .aclk     (aclk),
        .ctl      (ctl),
        .start_pt (in_sx),
        .end_pt   (in_fx),
        .pos      (px)
    );

    scs_axis u_axis_y (
        .aclk     (aclk),
        .ctl      (ctl),
        .start_pt (in_sy),
        .end_pt   (in_fy),
        .pos      (py)
    );

    // offsets of the current sample from the center
    always_comb begin
        diff_x = {px[COORD_W-1], px} - {cx_reg[COORD_W-1], cx_reg};
        diff_y = {py[COORD_W-1], py} - {cy_reg[COORD_W-1], cy_reg};
        mag_x  = diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
        mag_y  = diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
    end

    // squarer operand: radius and band bounds during setup, then x and y offsets in turn
    always_comb begin
        case (state_reg)
            S_DIV: begin
                case (cnt_reg)
                    DCNT_W'(1): mul_op = lo_reg;
                    DCNT_W'(2): mul_op = hi_reg;
                    default:    mul_op = COORD_W'(r_reg);
                endcase
            end
            S_WB:    mul_op = mag_y;
            default: mul_op = mag_x;
        endcase
    end

    scs_square u_square (
        .aclk    (aclk),
        .operand (mul_op),
        .product (prod)
    );

    // distance test of the held sample
    always_comb begin
        d2        = {1'b0, sqx_reg} + {1'b0, prod};
        hit       = ({1'b0, lo2_reg} <= d2) && (d2 <= {1'b0, hi2_reg});
        in_circle = (d2 < {1'b0, r2_reg});
    end

    // sequencer, configuration register and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            tol_reg      <= TOL_RESET;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            k_reg        <= '0;
            have_reg     <= 1'b0;
            last_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_reg     <= in_r;
                        lo_reg    <= in_lo;
                        hi_reg    <= COORD_W'(in_hi);
                        cx_reg    <= in_cx;
                        cy_reg    <= in_cy;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    // squares of r, lo and hi come out in the cycle after their operand
                    case (cnt_reg)
                        DCNT_W'(1): r2_reg  <= prod;
                        DCNT_W'(2): lo2_reg <= prod;
                        DCNT_W'(3): hi2_reg <= prod;
                        default: ;
                    endcase
                    cnt_reg <= cnt_reg + DCNT_W'(1);
                    if (cnt_reg == DCNT_W'(SETUP_CYC - 1)) begin
                        k_reg     <= '0;
                        have_reg  <= 1'b0;
                        last_reg  <= 1'b0;
                        res_x_reg <= '0;
                        res_y_reg <= '0;
                        kind_reg  <= KIND_NONE;
                        state_reg <= S_WA;
                    end
                end
                S_WA: begin
                    if (have_reg && hit) begin
                        res_x_reg <= hold_x_reg;
                        res_y_reg <= hold_y_reg;
                        kind_reg  <= KIND_HIT;
                        state_reg <= S_OUT;
                    end else begin
                        if (have_reg && in_circle) begin
                            res_x_reg <= hold_x_reg;
                            res_y_reg <= hold_y_reg;
                            kind_reg  <= KIND_INSIDE;
                        end
                        if (have_reg && last_reg) begin
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_WB;
                        end
                    end
                end
                S_WB: begin
                    sqx_reg    <= prod;
                    hold_x_reg <= px;
                    hold_y_reg <= py;
                    have_reg   <= 1'b1;
                    last_reg   <= (k_reg == K_W'(STEPS - 1));
                    k_reg      <= k_reg + K_W'(1);
                    state_reg  <= S_WA;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= OUT_W'({res_y_reg, res_x_reg});
                        m_tuser_reg  <= kind_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a result kind is always one of the three defined codes
    a_kind_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_NONE || m_tuser == KIND_INSIDE || m_tuser == KIND_HIT))
        else $error("undefined match kind on result beat");

    // no point found reports the origin
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_NONE) |-> (m_tdata == '0))
        else $error("empty result with nonzero point");

    // an accepted beat always starts the division
    a_accept_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_DIV))
        else $error("accepted beat did not start setup");

    // the walk never runs past the last sample
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WA || state_reg == S_WB) |-> (k_reg <= K_W'(STEPS)))
        else $error("sample counter ran past the segment");

endmodule

@@ tb/contact_checker.sv @@
// ----------------------------------------------------------------------------
// contact_checker
// Watches the configuration port and both stream channels of the segment /
// circle contact search, predicts the contact point of every accepted input
// beat and compares it with the result beats in order.
// ----------------------------------------------------------------------------
module contact_checker
    import scs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [TOL_W-1:0]   cfg_wdata,
    input  logic               s_tvalid,
    input  logic               s_tready,
    // fields from bit 0: circle_radius, center_x, center_y, first_x, first_y,
    // second_x, second_y, zero fill
    input  logic [IN_W-1:0]    s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    // fields from bit 0: contact_x, contact_y
    input  logic [OUT_W-1:0]   m_tdata,
    // fields from bit 0: match_kind
    input  logic [KIND_W-1:0]  m_tuser,
    input  logic               end_of_run,
    output int                 fail_count,
    output int                 outstanding,
    output int                 n_none,
    output int                 n_inside,
    output int                 n_hit
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [KIND_W-1:0]  kind;
    } contact_t;

    contact_t         contact_q[$];
    logic [TOL_W-1:0] tol_copy;
    logic             end_seen;

    // one line per failure, printing stops after a while but counting does not
    task automatic report_error(input string what);
        fail_count++;
        if (fail_count <= PRINT_CAP) begin
            $display("[%0t] ERROR: %s", $time, what);
        end
    endtask

    // walk the samples from the second end toward the first end
    function automatic contact_t find_contact(input logic [IN_W-1:0] beat,
                                              input logic [TOL_W-1:0] tol);
        longint   rad, tol_l, cx, cy, fx, fy, sx, sy, dx, dy;
        longint   lo, hi, px, py, ex, ey, d2;
        contact_t best;
        int       k;
        rad   = longint'(beat[0 +: RAD_W]);
        tol_l = longint'(tol);
        cx    = longint'($signed(beat[RAD_W +: COORD_W]));
        cy    = longint'($signed(beat[RAD_W + COORD_W +: COORD_W]));
        fx    = longint'($signed(beat[RAD_W + 2 * COORD_W +: COORD_W]));
        fy    = longint'($signed(beat[RAD_W + 3 * COORD_W +: COORD_W]));
        sx    = longint'($signed(beat[RAD_W + 4 * COORD_W +: COORD_W]));
        sy    = longint'($signed(beat[RAD_W + 5 * COORD_W +: COORD_W]));
        dx    = fx - sx;
        dy    = fy - sy;
        // lower bound clamps at zero when the tolerance covers the radius
        lo    = (rad > tol_l) ? rad - tol_l : 0;
        hi    = rad + tol_l;
        best.x    = '0;
        best.y    = '0;
        best.kind = KIND_NONE;
        k = 0;
        while (k < STEPS && best.kind != KIND_HIT) begin
            // signed division truncates toward zero
            px = sx + (dx * k) / STEPS;
            py = sy + (dy * k) / STEPS;
            ex = px - cx;
            ey = py - cy;
            d2 = ex * ex + ey * ey;
            if (d2 >= lo * lo && d2 <= hi * hi) begin
                best.x    = px[COORD_W-1:0];
                best.y    = py[COORD_W-1:0];
                best.kind = KIND_HIT;
            end else if (d2 < rad * rad) begin
                best.x    = px[COORD_W-1:0];
                best.y    = py[COORD_W-1:0];
                best.kind = KIND_INSIDE;
            end
            k++;
        end
        return best;
    endfunction

    // track the tolerance, queue predictions, compare result beats
    always @(posedge aclk) begin : watch
        contact_t want;
        contact_t got;
        if (!aresetn) begin
            tol_copy    <= TOL_RESET;
            end_seen    <= 1'b0;
            outstanding <= 0;
            contact_q.delete();
        end else begin
            if (cfg_we) begin
                tol_copy <= cfg_wdata;
            end
            // result side first, so a beat cannot match its own input
            if (m_tvalid && m_tready) begin
                got.x    = m_tdata[0 +: COORD_W];
                got.y    = m_tdata[COORD_W +: COORD_W];
                got.kind = m_tuser;
                if (contact_q.size() == 0) begin
                    report_error($sformatf("result (%0d,%0d) kind %0d with nothing expected",
                        $signed(got.x), $signed(got.y), got.kind));
                end else begin
                    want = contact_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.kind !== want.kind) begin
                        report_error($sformatf("got (%0d,%0d) kind %0d, want (%0d,%0d) kind %0d",
                            $signed(got.x), $signed(got.y), got.kind,
                            $signed(want.x), $signed(want.y), want.kind));
                    end
                    case (want.kind)
                        KIND_HIT:    n_hit++;
                        KIND_INSIDE: n_inside++;
                        default:     n_none++;
                    endcase
                end
            end
            if (s_tvalid && s_tready) begin
                contact_q.push_back(find_contact(s_tdata, tol_copy));
            end
            // anything still queued at the end never arrived
            if (end_of_run && !end_seen) begin
                end_seen <= 1'b1;
                if (contact_q.size() != 0) begin
                    report_error($sformatf("%0d expected results never arrived",
                        contact_q.size()));
                end
            end
            outstanding <= contact_q.size();
        end
    end

endmodule

@@ tb/tb_segment_circle_contact_search.sv @@
// ----------------------------------------------------------------------------
// tb_segment_circle_contact_search
// Drives directed and random segment / circle beats through the contact search
// under several tolerance settings, with bursty input, a stalling receiver and
// a long output hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_segment_circle_contact_search;
    import scs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_PERIOD      = 10;
    localparam int     RESET_CYCLES    = 8;
    localparam int     ITEMS_PER_PHASE = 122;
    localparam int     PRESSURE_ITEMS  = 6;
    localparam int     RX_HOLD_CYCLES  = 2000;
    localparam int     DRAIN_CYCLES    = 2 * STEPS + COORD_W + 3;
    localparam int     CYCLE_LIMIT     = 3000000;
    localparam longint CMAX            = 64'sd8388607;
    localparam longint CMIN            = -64'sd8388608;
    localparam longint RMAX            = 64'sd8388607;

    typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_RUNS} rx_mode_t;

    logic               aclk       = 1'b0;
    logic               aresetn    = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [TOL_W-1:0]   cfg_wdata  = '0;
    logic               s_tvalid   = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata    = '0;
    logic               m_tvalid;
    logic               m_tready   = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic [KIND_W-1:0]  m_tuser;
    logic               end_of_run = 1'b0;
    logic               rx_hold    = 1'b0;

    int fail_count;
    int outstanding;
    int n_none;
    int n_inside;
    int n_hit;
    int n_sent      = 0;
    int n_settings  = 0;
    int cycle_count = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    segment_circle_contact_search uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    contact_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .end_of_run  (end_of_run),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .n_none      (n_none),
        .n_inside    (n_inside),
        .n_hit       (n_hit)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycle_count, outstanding);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: own stall pattern, plus a long hold-off on a one-cycle request
    initial begin : rx_side
        rx_mode_t mode;
        int       left;
        int       run;
        int       i;
        logic     run_lvl;
        mode    = RX_ALWAYS;
        left    = 0;
        run     = 0;
        run_lvl = 1'b1;
        forever begin
            @(posedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
                for (i = 0; i < RX_HOLD_CYCLES; i++) begin
                    @(posedge aclk);
                end
            end else begin
                if (left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(50, 400);
                end
                left--;
                case (mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_HALF:   m_tready <= ($urandom_range(0, 1) == 0);
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        if (run == 0) begin
                            run_lvl = ~run_lvl;
                            run     = $urandom_range(1, 30);
                        end
                        run--;
                        m_tready <= run_lvl;
                    end
                endcase
            end
        end
    end

    // fields are cut to their widths, so out-of-range sums simply wrap
    function automatic logic [IN_W-1:0] pack_job(input longint r, input longint cx,
                                                 input longint cy, input longint fx,
                                                 input longint fy, input longint sx,
                                                 input longint sy);
        return IN_W'({sy[COORD_W-1:0], sx[COORD_W-1:0], fy[COORD_W-1:0],
                      fx[COORD_W-1:0], cy[COORD_W-1:0], cx[COORD_W-1:0], r[RAD_W-1:0]});
    endfunction

    function automatic longint rand_offset(input longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    function automatic longint rand_sign();
        return ($urandom_range(0, 1) == 0) ? 64'sd1 : -64'sd1;
    endfunction

    // mostly segments near the circle, some degenerate or tiny ones, some noise
    function automatic logic [IN_W-1:0] random_job();
        int unsigned     pick;
        int unsigned     sh;
        longint          r, m, cx, cy, fx, fy, sx, sy, reach;
        logic [IN_W-1:0] noise;
        pick  = $urandom_range(0, 99);
        sh    = $urandom_range(1, 22);
        r     = longint'($urandom_range(0, (1 << sh) - 1));
        cx    = rand_offset(1 << 22);
        cy    = rand_offset(1 << 22);
        reach = 2 * r + 16;
        sx    = cx + rand_offset(reach);
        sy    = cy + rand_offset(reach);
        fx    = cx + rand_offset(reach);
        fy    = cy + rand_offset(reach);
        if (pick >= 45 && pick < 65) begin
            // walk starts on the circle or within a few units of it
            if ($urandom_range(0, 1) == 0) begin
                sx = cx + rand_sign() * r + rand_offset(3);
                sy = cy + rand_offset(2);
            end else begin
                m  = r / 5;
                r  = 5 * m;
                sx = cx + rand_sign() * 3 * m + rand_offset(3);
                sy = cy + rand_sign() * 4 * m + rand_offset(3);
            end
        end else if (pick >= 65 && pick < 75) begin
            // both ends coincide
            fx = sx;
            fy = sy;
        end else if (pick >= 75 && pick < 85) begin
            // tiny circle, tolerance often covers the radius
            r  = longint'($urandom_range(0, 12));
            sx = cx + rand_offset(200);
            sy = cy + rand_offset(200);
            fx = cx + rand_offset(200);
            fy = cy + rand_offset(200);
        end else if (pick >= 85) begin
            noise = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            return noise & ((IN_W'(1) << IN_FLD_W) - IN_W'(1));
        end
        return pack_job(r, cx, cy, fx, fy, sx, sy);
    endfunction

    // offer one beat, valid stays up until the caller lowers it
    task automatic offer_beat(input logic [IN_W-1:0] beat);
        s_tdata  <= beat;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        n_sent++;
    endtask

    // valid must already be low
    task automatic wait_all_results();
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        n_settings++;
    endtask

    // bursts of beats with random gaps, now and then a full drain
    task automatic random_phase(input int n_items);
        int sent;
        int burst;
        int gap;
        int i;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 8);
            for (i = 0; i < burst && sent < n_items; i++) begin
                offer_beat(random_job());
                sent++;
            end
            if ($urandom_range(0, 24) == 0) begin
                s_tvalid <= 1'b0;
                wait_all_results();
            end else begin
                case ($urandom_range(0, 7))
                    0, 1:    gap = 0;
                    2:       gap = $urandom_range(100, 300);
                    default: gap = $urandom_range(1, 40);
                endcase
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [TOL_W-1:0] tol_plan [6];
        int               p;
        int               i;
        tol_plan[0] = TOL_W'(0);
        tol_plan[1] = TOL_W'(255);
        tol_plan[2] = TOL_W'(1);
        tol_plan[3] = TOL_W'(128);
        tol_plan[4] = TOL_W'($urandom_range(2, 254));
        tol_plan[5] = TOL_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        n_settings = 1;

        // directed beats under the reset tolerance
        offer_beat(pack_job(0, 0, 0, 0, 0, 0, 0));
        offer_beat(pack_job(RMAX, 0, 0, 0, 0, 0, 0));
        offer_beat(pack_job(25600, 0, 0, -51200, 0, 25600, 0));
        offer_beat(pack_job(25600, 0, 0, 51200, 0, -51200, 0));
        offer_beat(pack_job(25600, 0, 0, 25600, 0, 0, 0));
        offer_beat(pack_job(256, 0, 0, 200000, -50000, 100000, 100000));
        offer_beat(pack_job(1000, 0, 0, 10, 20, 10, 20));
        offer_beat(pack_job(256, 0, 0, 256, 0, 256, 0));
        offer_beat(pack_job(10, 0, 0, 5000, 5000, 5000, 5000));
        offer_beat(pack_job(RMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX));
        offer_beat(pack_job(RMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN));
        offer_beat(pack_job(RMAX, 0, 0, CMAX, CMIN, CMIN, CMAX));
        offer_beat(pack_job(RMAX, 0, 0, CMAX, CMAX, CMIN, CMIN));
        offer_beat(pack_job(2, 1000, 1000, 1500, 1000, 500, 1000));
        offer_beat(pack_job(2560, 0, 0, -5000, 2560, 5000, 2560));
        offer_beat(pack_job(5000, 0, 0, -3000, 4000, 3000, 4000));
        offer_beat(pack_job(1, 0, 0, -7, 7, 7, -7));
        offer_beat(pack_job(256, 0, 0, 0, 0, 252, 0));
        offer_beat(pack_job('h555555, 'hAAAAAA, 'h555555, 'hAAAAAA, 'h555555,
                            'hAAAAAA, 'h555555));
        offer_beat(pack_job('h2AAAAA, 'h555555, 'hAAAAAA, 'h555555, 'hAAAAAA,
                            'h555555, 'hAAAAAA));
        s_tvalid <= 1'b0;
        wait_all_results();

        // random phases, one tolerance setting each, changed only when drained
        for (p = 0; p < 6; p++) begin
            write_tolerance(tol_plan[p]);
            if (p == 2) begin
                // receiver holds off while beats keep coming
                rx_hold <= 1'b1;
                @(posedge aclk);
                rx_hold <= 1'b0;
                for (i = 0; i < PRESSURE_ITEMS; i++) begin
                    offer_beat(random_job());
                end
            end
            random_phase(ITEMS_PER_PHASE);
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        end_of_run <= 1'b1;
        repeat (3) @(posedge aclk);

        $display("covered %0d input beats over %0d tolerance settings, 0 and 255 included",
            n_sent, n_settings);
        $display("results checked: %0d none, %0d inside, %0d hit, %0d failures",
            n_none, n_inside, n_hit, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/scs_pkg.sv
design/scs_axis.sv
design/scs_square.sv
design/segment_circle_contact_search.sv
tb/contact_checker.sv
tb/tb_segment_circle_contact_search.sv
